// ----- hdl/polygon_centroid_area_macros.svh -----
// Assertion helpers for the checker of the polygon centroid block.
// Each macro expands to one labeled concurrent assertion, sampled on clk
// and switched off while arst_n is low.
`ifndef POLYGON_CENTROID_AREA_MACROS_SVH
`define POLYGON_CENTROID_AREA_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pca_pkg.sv -----
package pca_pkg;

	// Limits and field widths.
	localparam int MAX_VERTICES = 1024;
	localparam int MIN_VERTICES = 3;
	localparam int COORD_W      = 16;
	localparam int STATUS_W     = 2;
	localparam int TOL_W        = 32;
	localparam int AREA_OUT_W   = 34;

	// Internal arithmetic widths.
	localparam int CROSS_W   = 2 * COORD_W + 1;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int PROD_W    = CROSS_W + EDGE_W;
	localparam int AREA_W    = 44;
	localparam int SUM_W     = 62;
	localparam int DIVISOR_W = AREA_W + 2;
	localparam int QUOT_W    = COORD_W;

	// Record queue between the accumulating front end and the finishing back end.
	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_COUNT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd2;

	// One finished polygon, as handed from the front end to the back end.
	typedef struct packed {
		logic                     ok;
		logic signed [AREA_W-1:0] area;
		logic signed [SUM_W-1:0]  sum_x;
		logic signed [SUM_W-1:0]  sum_y;
	} poly_rec_t;

endpackage

// ----- hdl/pca_div.sv -----
module pca_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pca_pkg::SUM_W-1:0]          dividend,
	input  logic [pca_pkg::DIVISOR_W-1:0]      divisor,
	output logic                               done,
	output logic [pca_pkg::QUOT_W-1:0]         quot
);

	localparam int DSH_W  = pca_pkg::DIVISOR_W + pca_pkg::QUOT_W - 1;
	localparam int STEP_W = $clog2(pca_pkg::QUOT_W);

	logic                         busy_q;
	logic                         done_q;
	logic [STEP_W-1:0]            step_q;
	logic [pca_pkg::SUM_W-1:0]    rem_q;
	logic [DSH_W-1:0]             dsh_q;
	logic [pca_pkg::QUOT_W-1:0]   quot_q;
	logic                         ge;

	// One restoring step: does the shifted divisor fit into the remainder?
	assign ge = rem_q >= pca_pkg::SUM_W'(dsh_q);

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(pca_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	// Remainder, shifted divisor and quotient bits, most significant bit first.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= {divisor, {(pca_pkg::QUOT_W-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - pca_pkg::SUM_W'(dsh_q);
			end
			quot_q <= {quot_q[pca_pkg::QUOT_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hdl/pca_front.sv -----
module pca_front #(
	parameter int MAX_VERTICES = pca_pkg::MAX_VERTICES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pca_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [pca_pkg::COORD_W-1:0]  vertex_y,
	input  logic                                last_vertex,
	input  logic [pca_pkg::LVL_W-1:0]           q_level,
	output logic                                push,
	output pca_pkg::poly_rec_t                  push_rec
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 2);
	localparam int PEND_W = pca_pkg::LVL_W + 2;

	typedef struct packed {
		logic edge_vld;
		logic close;
		logic ok;
	} stage_ctl_t;

	// Polygon tracking state.
	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   count_nxt;
	logic signed [pca_pkg::COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                               close_pend_q;
	logic                               poly_ok_q;
	logic                               in_acc;
	logic                               cnt_lt;
	logic                               close_go;
	logic [PEND_W-1:0]                  pending;

	// Edge issue.
	stage_ctl_t                         ctl_c;
	logic signed [pca_pkg::COORD_W-1:0] xa_c, ya_c, xb_c, yb_c;

	// Pipeline stages.
	stage_ctl_t                         ctl_s1, ctl_s2, ctl_s3;
	logic signed [pca_pkg::COORD_W-1:0] xa_s1, ya_s1, xb_s1, yb_s1;
	logic signed [2*pca_pkg::COORD_W-1:0] p1_c, p2_c;
	logic signed [pca_pkg::CROSS_W-1:0] cross_s2, cross_s3;
	logic signed [pca_pkg::EDGE_W-1:0]  sx_s2, sy_s2;
	logic signed [pca_pkg::PROD_W-1:0]  px_c, py_c, px_s3, py_s3;

	// Accumulators.
	logic signed [pca_pkg::AREA_W-1:0]  area_q, area_add;
	logic signed [pca_pkg::SUM_W-1:0]   cx_q, cy_q, cx_add, cy_add;

	// The input stalls after a last vertex until the closing edge is issued.
	assign in_stall = close_pend_q;
	assign in_acc   = in_valid && !close_pend_q;
	assign cnt_lt   = count_q < CNT_W'(MAX_VERTICES);
	assign count_nxt = cnt_lt ? count_q + CNT_W'(1) : CNT_W'(MAX_VERTICES + 1);

	// A closing edge goes out only when its record is sure of a queue slot.
	assign pending = PEND_W'(q_level) + PEND_W'(ctl_s1.close) + PEND_W'(ctl_s2.close)
		+ PEND_W'(ctl_s3.close);
	assign close_go = close_pend_q && (pending < PEND_W'(pca_pkg::QUEUE_DEPTH));

	// Pick the edge for this cycle: the closing edge or the edge into the new vertex.
	always_comb begin
		ctl_c = '0;
		xa_c  = prev_x_q;
		ya_c  = prev_y_q;
		xb_c  = vertex_x;
		yb_c  = vertex_y;
		if (close_go) begin
			ctl_c.edge_vld = poly_ok_q;
			ctl_c.close    = 1'b1;
			ctl_c.ok       = poly_ok_q;
			xb_c           = first_x_q;
			yb_c           = first_y_q;
		end else if (in_acc && cnt_lt && (count_q != '0)) begin
			ctl_c.edge_vld = 1'b1;
		end
	end

	// Vertex count, first and previous vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			close_pend_q <= 1'b0;
			poly_ok_q    <= 1'b0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
		end else begin
			if (in_acc) begin
				if (cnt_lt) begin
					if (count_q == '0) begin
						first_x_q <= vertex_x;
						first_y_q <= vertex_y;
					end
					prev_x_q <= vertex_x;
					prev_y_q <= vertex_y;
				end
				count_q <= count_nxt;
				if (last_vertex) begin
					close_pend_q <= 1'b1;
					poly_ok_q    <= (count_nxt >= CNT_W'(pca_pkg::MIN_VERTICES))
						&& (count_nxt <= CNT_W'(MAX_VERTICES));
				end
			end
			if (close_go) begin
				close_pend_q <= 1'b0;
				count_q      <= '0;
			end
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 1 forms the cross product, stage 2 weights it by the coordinate sums.
	assign p1_c = xa_s1 * yb_s1;
	assign p2_c = xb_s1 * ya_s1;
	assign px_c = sx_s2 * cross_s2;
	assign py_c = sy_s2 * cross_s2;

	always_ff @(posedge clk) begin
		xa_s1    <= xa_c;
		ya_s1    <= ya_c;
		xb_s1    <= xb_c;
		yb_s1    <= yb_c;
		cross_s2 <= pca_pkg::CROSS_W'(p1_c) - pca_pkg::CROSS_W'(p2_c);
		sx_s2    <= pca_pkg::EDGE_W'(xa_s1) + pca_pkg::EDGE_W'(xb_s1);
		sy_s2    <= pca_pkg::EDGE_W'(ya_s1) + pca_pkg::EDGE_W'(yb_s1);
		cross_s3 <= cross_s2;
		px_s3    <= px_c;
		py_s3    <= py_c;
	end

	// Stage 3 adds the edge into the running sums.
	assign area_add = area_q + (ctl_s3.edge_vld ? pca_pkg::AREA_W'(cross_s3) : '0);
	assign cx_add   = cx_q + (ctl_s3.edge_vld ? pca_pkg::SUM_W'(px_s3) : '0);
	assign cy_add   = cy_q + (ctl_s3.edge_vld ? pca_pkg::SUM_W'(py_s3) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (ctl_s3.close) begin
			area_q <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else begin
			area_q <= area_add;
			cx_q   <= cx_add;
			cy_q   <= cy_add;
		end
	end

	// The closing edge hands the finished polygon to the queue.
	assign push           = ctl_s3.close;
	assign push_rec.ok    = ctl_s3.ok;
	assign push_rec.area  = area_add;
	assign push_rec.sum_x = cx_add;
	assign push_rec.sum_y = cy_add;

endmodule

// ----- hdl/pca_queue.sv -----
module pca_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  pca_pkg::poly_rec_t            push_rec,
	input  logic                          pop,
	output pca_pkg::poly_rec_t            head_rec,
	output logic                          empty,
	output logic [pca_pkg::LVL_W-1:0]     level
);

	pca_pkg::poly_rec_t               mem_q [pca_pkg::QUEUE_DEPTH];
	logic [pca_pkg::QIDX_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [pca_pkg::LVL_W-1:0]        level_q;

	// Entry storage; the writer never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pca_pkg::QIDX_W'(pca_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + pca_pkg::QIDX_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pca_pkg::QIDX_W'(pca_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + pca_pkg::QIDX_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + pca_pkg::LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - pca_pkg::LVL_W'(1);
			end
		end
	end

	assign head_rec = mem_q[rd_ptr_q];
	assign empty    = (level_q == '0);
	assign level    = level_q;

endmodule

// ----- hdl/pca_back.sv -----
module pca_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [pca_pkg::TOL_W-1:0]             area_tol,
	input  logic                                  q_empty,
	input  pca_pkg::poly_rec_t                    q_head,
	output logic                                  q_pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pca_pkg::STATUS_W-1:0]          status,
	output logic signed [pca_pkg::COORD_W-1:0]    centroid_x,
	output logic signed [pca_pkg::COORD_W-1:0]    centroid_y,
	output logic signed [pca_pkg::AREA_OUT_W-1:0] signed_area
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_CLASS = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam int AW = pca_pkg::AREA_W;
	localparam int OW = pca_pkg::AREA_OUT_W;
	localparam int SW = pca_pkg::SUM_W;
	localparam int CW = pca_pkg::COORD_W;

	logic [2:0]                        state_q;
	logic                              out_valid_q;
	pca_pkg::poly_rec_t                rec_q;
	logic [AW-1:0]                     mag_q;
	logic [OW-1:0]                     area_sat_q;
	logic [pca_pkg::STATUS_W-1:0]      status_q;
	logic [pca_pkg::DIVISOR_W-1:0]     dvsr_q;
	logic [SW-1:0]                     numx_q, numy_q;
	logic                              negx_q, negy_q;
	logic [pca_pkg::STATUS_W-1:0]      status_out_q;
	logic [CW-1:0]                     cent_x_q, cent_y_q;
	logic [OW-1:0]                     area_out_q;

	logic                              area_neg;
	logic [AW-1:0]                     area_abs;
	logic                              area_fits;
	logic [OW-1:0]                     area_sat;
	logic                              out_free;
	logic                              div_start;
	logic                              done_x, done_y;
	logic [pca_pkg::QUOT_W-1:0]        quot_x, quot_y;

	// Magnitude of a signed sum.
	function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
		mag_of = v[SW-1] ? (~v + SW'(1)) : v;
	endfunction

	// Signed Q8.8 centroid from a quotient magnitude; a set top bit means overflow.
	function automatic logic [CW-1:0] signed_quot(input logic [pca_pkg::QUOT_W-1:0] q,
		input logic neg);
		logic [CW-1:0] r;
		if (q[pca_pkg::QUOT_W-1]) begin
			r = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			r = neg ? (~CW'(q) + CW'(1)) : CW'(q);
		end
		return r;
	endfunction

	// Area magnitude and saturation to the output width.
	assign area_neg  = rec_q.area[AW-1];
	assign area_abs  = area_neg ? (~rec_q.area + AW'(1)) : rec_q.area;
	assign area_fits = (&rec_q.area[AW-1:OW-1]) || !(|rec_q.area[AW-1:OW-1]);
	assign area_sat  = area_fits ? rec_q.area[OW-1:0]
		: (area_neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign div_start = (state_q == ST_START);

	// Two restoring dividers, one per axis, run side by side.
	pca_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numx_q),
		.divisor  (dvsr_q),
		.done     (done_x),
		.quot     (quot_x)
	);

	pca_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numy_q),
		.divisor  (dvsr_q),
		.done     (done_y),
		.quot     (quot_y)
	);

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= rec_q.ok ? ST_CLASS : ST_FIN;
				end
				ST_CLASS: begin
					state_q <= (mag_q <= AW'(area_tol)) ? ST_FIN : ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (done_x && done_y) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and the output beat.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					rec_q <= q_head;
				end
			end
			ST_PREP: begin
				if (rec_q.ok) begin
					mag_q      <= area_abs;
					area_sat_q <= area_sat;
				end else begin
					status_q   <= pca_pkg::STATUS_COUNT;
					area_sat_q <= '0;
				end
			end
			ST_CLASS: begin
				if (mag_q <= AW'(area_tol)) begin
					status_q <= pca_pkg::STATUS_DEGEN;
				end else begin
					status_q <= pca_pkg::STATUS_OK;
				end
				dvsr_q <= pca_pkg::DIVISOR_W'(mag_q) + pca_pkg::DIVISOR_W'({mag_q, 1'b0});
				numx_q <= mag_of(rec_q.sum_x);
				numy_q <= mag_of(rec_q.sum_y);
				negx_q <= rec_q.sum_x[SW-1] ^ area_neg;
				negy_q <= rec_q.sum_y[SW-1] ^ area_neg;
			end
			ST_FIN: begin
				if (out_free) begin
					status_out_q <= status_q;
					area_out_q   <= area_sat_q;
					cent_x_q <= (status_q == pca_pkg::STATUS_OK) ? signed_quot(quot_x, negx_q) : '0;
					cent_y_q <= (status_q == pca_pkg::STATUS_OK) ? signed_quot(quot_y, negy_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_out_q;
	assign centroid_x  = cent_x_q;
	assign centroid_y  = cent_y_q;
	assign signed_area = area_out_q;

endmodule

// ----- hdl/polygon_centroid_area.sv -----
// Polygon centroid and area, one vertex per beat.
// Input channel: in_valid / in_stall carry vertex_x, vertex_y (signed Q8.8) and
// last_vertex, which closes the polygon. One result beat per polygon leaves on
// out_valid / out_stall: status, centroid_x, centroid_y and signed_area.
// Configuration: cfg_valid / cfg_ready write cfg_data into the area tolerance;
// cfg_ready is always high. Write it only while the block is idle.
// Throughput: vertices are taken every cycle while in_stall is low; each polygon
// holds the input after its last vertex until its closing edge is issued. The back
// end works on one record at a time: classification plus two 16-step restoring
// dividers; short polygons are throttled by the four-entry record queue.
// Invalid or degenerate polygons skip the dividers and finish sooner.
// A stalled result stays on the outputs; the front end keeps accumulating the next
// polygons until the queue fills, then holds in_stall high.
// Reset clears all polygon state, empties the queue and sets the tolerance to zero.
module polygon_centroid_area #(
	parameter int MAX_VERTICES = pca_pkg::MAX_VERTICES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pca_pkg::COORD_W-1:0]    vertex_x,
	input  logic signed [pca_pkg::COORD_W-1:0]    vertex_y,
	input  logic                                  last_vertex,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pca_pkg::STATUS_W-1:0]          status,
	output logic signed [pca_pkg::COORD_W-1:0]    centroid_x,
	output logic signed [pca_pkg::COORD_W-1:0]    centroid_y,
	output logic signed [pca_pkg::AREA_OUT_W-1:0] signed_area,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pca_pkg::TOL_W-1:0]             cfg_data
);

	logic [pca_pkg::TOL_W-1:0]  area_tol_q;
	logic                       q_push;
	pca_pkg::poly_rec_t         q_push_rec;
	logic                       q_pop;
	pca_pkg::poly_rec_t         q_head;
	logic                       q_empty;
	logic [pca_pkg::LVL_W-1:0]  q_level;

	// Tolerance register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_tol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			area_tol_q <= cfg_data;
		end
	end

	pca_front #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.q_level     (q_level),
		.push        (q_push),
		.push_rec    (q_push_rec)
	);

	pca_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_push_rec),
		.pop      (q_pop),
		.head_rec (q_head),
		.empty    (q_empty),
		.level    (q_level)
	);

	pca_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.area_tol    (area_tol_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.signed_area (signed_area)
	);

endmodule

// ----- hdl/pca_checker.sv -----
`include "polygon_centroid_area_macros.svh"

module pca_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  last_vertex,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [pca_pkg::STATUS_W-1:0]          status,
	input logic signed [pca_pkg::COORD_W-1:0]    centroid_x,
	input logic signed [pca_pkg::COORD_W-1:0]    centroid_y,
	input logic signed [pca_pkg::AREA_OUT_W-1:0] signed_area
);

	// A stalled result beat holds its payload.
	`PCA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(signed_area) && $stable(centroid_x) && $stable(centroid_y), "stalled result beat changed")

	// After a last vertex is accepted, the input stalls while the closing edge is issued.
	`PCA_ASSERT_NEXT(a_close_bubble, in_valid && !in_stall && last_vertex, in_stall, "no stall after last vertex")

	// Only a good polygon reports a centroid.
	`PCA_ASSERT_NOW(a_cent_zero, out_valid && (status != pca_pkg::STATUS_OK), (centroid_x == '0) && (centroid_y == '0), "centroid set on a failed polygon")

	// A bad vertex count reports no area.
	`PCA_ASSERT_NOW(a_count_area, out_valid && (status == pca_pkg::STATUS_COUNT), signed_area == '0, "area set on a bad vertex count")

endmodule

bind polygon_centroid_area pca_checker u_pca_checker (.*);

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pca_pkg::*;

	localparam int     NUM_PHASES     = 6;
	localparam int     PRESSURE_PHASE = 4;
	localparam int     HOLD_CYCLES    = 300;
	localparam int     DRAIN_CYCLES   = 40;
	localparam int     RANDOM_BUDGET  = 180;
	localparam longint LIMIT_CYCLES   = 500000;
	localparam longint AREA_HI        = (64'sd1 <<< (AREA_OUT_W - 1)) - 1;
	localparam longint AREA_LO        = -(64'sd1 <<< (AREA_OUT_W - 1));

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
	} vertex_t;

	typedef struct {
		logic [STATUS_W-1:0]          status;
		logic signed [COORD_W-1:0]    cx;
		logic signed [COORD_W-1:0]    cy;
		logic signed [AREA_OUT_W-1:0] area;
	} poly_result_t;

	logic                         clk;
	logic                         arst_n      = 1'b0;
	logic                         in_valid    = 1'b0;
	logic                         in_stall;
	logic signed [COORD_W-1:0]    vertex_x    = '0;
	logic signed [COORD_W-1:0]    vertex_y    = '0;
	logic                         last_vertex = 1'b0;
	logic                         out_valid;
	logic                         out_stall   = 1'b0;
	logic [STATUS_W-1:0]          status;
	logic signed [COORD_W-1:0]    centroid_x;
	logic signed [COORD_W-1:0]    centroid_y;
	logic signed [AREA_OUT_W-1:0] signed_area;
	logic                         cfg_valid   = 1'b0;
	logic                         cfg_ready;
	logic [TOL_W-1:0]             cfg_data    = '0;

	vertex_t      pending_vertices[$];
	poly_result_t expected_polygons[$];

	// Predictor copy of the tolerance register and the per-polygon accumulators.
	logic [TOL_W-1:0] tol_model = '0;
	longint poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
	longint acc_area2, acc_mx, acc_my;
	int     poly_count;

	int     send_idle_pct;
	int     stall_pct;
	int     phase_idx = -1;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	int     errors = 0;
	int     vertex_beats = 0;
	int     n_ok = 0, n_count = 0, n_degen = 0, n_sat = 0;
	int     tol_writes = 0;
	longint cycles = 0;

	polygon_centroid_area i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.signed_area(signed_area),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Adds one edge a -> b to the doubled area and the centroid moment sums.
	task automatic accumulate_edge(input longint xa, input longint ya,
		input longint xb, input longint yb);
		longint cross_term;
		cross_term = xa * yb - xb * ya;
		acc_area2 += cross_term;
		acc_mx += (xa + xb) * cross_term;
		acc_my += (ya + yb) * cross_term;
	endtask

	function automatic logic signed [COORD_W-1:0] clamp_q88(input longint q);
		if (q > 32767)
			return 16'sh7fff;
		if (q < -32768)
			return 16'sh8000;
		return q[COORD_W-1:0];
	endfunction

	task automatic clear_polygon();
		poly_first_x = 0;
		poly_first_y = 0;
		poly_prev_x = 0;
		poly_prev_y = 0;
		poly_count = 0;
		acc_area2 = 0;
		acc_mx = 0;
		acc_my = 0;
	endtask

	// Shoelace predictor: takes one accepted vertex and queues the polygon result on the last one.
	task automatic shoelace_step(input vertex_t v);
		longint x, y, twice, mag, tol_val, div;
		poly_result_t r;
		x = v.x;
		y = v.y;
		if (poly_count < MAX_VERTICES) begin
			if (poly_count == 0) begin
				poly_first_x = x;
				poly_first_y = y;
			end else begin
				accumulate_edge(poly_prev_x, poly_prev_y, x, y);
			end
			poly_prev_x = x;
			poly_prev_y = y;
			poly_count++;
		end else begin
			poly_count = MAX_VERTICES + 1;
		end
		if (v.last) begin
			r.status = STATUS_OK;
			r.cx = '0;
			r.cy = '0;
			r.area = '0;
			if (poly_count < MIN_VERTICES || poly_count > MAX_VERTICES) begin
				r.status = STATUS_COUNT;
			end else begin
				accumulate_edge(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
				twice = acc_area2;
				mag = twice < 0 ? -twice : twice;
				tol_val = tol_model;
				r.area = AREA_OUT_W'(twice > AREA_HI ? AREA_HI
					: (twice < AREA_LO ? AREA_LO : twice));
				if (mag <= tol_val) begin
					r.status = STATUS_DEGEN;
				end else begin
					div = 3 * twice;
					r.cx = clamp_q88(acc_mx / div);
					r.cy = clamp_q88(acc_my / div);
				end
			end
			expected_polygons.push_back(r);
			clear_polygon();
		end
	endtask

	// Vertex driver: holds a beat while stalled, otherwise offers the next one or idles.
	always @(posedge clk) begin : drive_vertices
		bit offer;
		if (arst_n) begin
			offer = !in_valid;
			if (in_valid && !in_stall) begin
				shoelace_step(pending_vertices.pop_front());
				vertex_beats++;
				offer = 1'b1;
			end
			if (offer) begin
				if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					vertex_x <= pending_vertices[0].x;
					vertex_y <= pending_vertices[0].y;
					last_vertex <= pending_vertices[0].last;
				end else begin
					in_valid <= 1'b0;
					vertex_x <= COORD_W'($urandom);
					vertex_y <= COORD_W'($urandom);
					last_vertex <= 1'($urandom);
				end
			end
		end
	end

	// One long receiver hold-off while the sender keeps offering, so the record queue fills.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0)
				hold_left <= hold_left - 1;
			else if (!hold_done && phase_idx == PRESSURE_PHASE && in_valid) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	task automatic compare_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Result monitor: checks each accepted beat against the oldest expected polygon.
	always @(posedge clk) begin : watch_results
		poly_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_polygons.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, actual status %0d area %0d",
						$time, status, signed_area);
					errors++;
				end else begin
					want = expected_polygons.pop_front();
					compare_field("status", want.status, status);
					compare_field("centroid_x", want.cx, centroid_x);
					compare_field("centroid_y", want.cy, centroid_y);
					compare_field("signed_area", want.area, signed_area);
					case (want.status)
						STATUS_OK:    n_ok++;
						STATUS_COUNT: n_count++;
						default:      n_degen++;
					endcase
					if (want.area == AREA_HI || want.area == AREA_LO ||
						want.cx == 16'sh7fff || want.cx == 16'sh8000 ||
						want.cy == 16'sh7fff || want.cy == 16'sh8000)
						n_sat++;
				end
			end
			out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
		end
	end

	// Cycle limit guards against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t ns: timeout with %0d results still expected", $time,
				expected_polygons.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_vertex(input int x, input int y, input bit last);
		vertex_t v;
		v.x = COORD_W'(x);
		v.y = COORD_W'(y);
		v.last = last;
		pending_vertices.push_back(v);
	endtask

	function automatic int random_coord(input int span);
		if (span >= 32768)
			return int'($urandom);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Full-range square, walked the given number of laps in either direction.
	task automatic add_square(input bit ccw, input int laps);
		int xs[4], ys[4];
		int idx;
		xs = '{-32768, 32767, 32767, -32768};
		ys = '{-32768, -32768, 32767, 32767};
		for (int k = 0; k < 4 * laps; k++) begin
			idx = ccw ? k % 4 : 3 - k % 4;
			add_vertex(xs[idx], ys[idx], k == 4 * laps - 1);
		end
	endtask

	// Mostly well-formed polygons with random content, plus short and collinear ones.
	task automatic add_random_polygons(input int budget);
		int added, kind, n, span, x0, y0, dx, dy, xa, ya, xb, yb;
		added = 0;
		while (added < budget) begin
			kind = $urandom_range(99);
			if (kind < 6) begin
				n = $urandom_range(1, 2);
				for (int k = 0; k < n; k++)
					add_vertex(random_coord(32768), random_coord(32768), k == n - 1);
			end else if (kind < 16) begin
				n = $urandom_range(3, 6);
				x0 = random_coord(8000);
				y0 = random_coord(8000);
				dx = random_coord(1000);
				dy = random_coord(1000);
				for (int k = 0; k < n; k++)
					add_vertex(x0 + k * dx, y0 + k * dy, k == n - 1);
			end else if (kind < 30) begin
				n = 4;
				xa = random_coord(32768);
				ya = random_coord(32768);
				xb = random_coord(32768);
				yb = random_coord(32768);
				add_vertex(xa, ya, 1'b0);
				add_vertex(xb, ya, 1'b0);
				add_vertex(xb, yb, 1'b0);
				add_vertex(xa, yb, 1'b1);
			end else begin
				n = $urandom_range(3, 8);
				span = (kind < 55) ? 32768 : $urandom_range(16, 4096);
				for (int k = 0; k < n; k++)
					add_vertex(random_coord(span), random_coord(span), k == n - 1);
			end
			added += n;
		end
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tol_model = value;
		tol_writes++;
	endtask

	initial begin
		clear_polygon();
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			phase_idx = p;
			// Idling: sender light and receiver heavy, then swapped, then none.
			case (p / 2)
				0: begin
					send_idle_pct = 28;
					stall_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					stall_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase

			case (p)
				0: begin
					write_tolerance('0);
					// Counterclockwise and clockwise triangles.
					add_vertex(0, 0, 1'b0);
					add_vertex(768, 0, 1'b0);
					add_vertex(0, 768, 1'b1);
					add_vertex(0, 768, 1'b0);
					add_vertex(768, 0, 1'b0);
					add_vertex(0, 0, 1'b1);
					// Too few vertices: one, then two.
					add_vertex(32767, -32768, 1'b1);
					add_vertex(-32768, 32767, 1'b0);
					add_vertex(100, 100, 1'b1);
					// Collinear points have zero area.
					add_vertex(-100, -100, 1'b0);
					add_vertex(0, 0, 1'b0);
					add_vertex(200, 200, 1'b1);
					// Full-range square, then the same square twice to saturate the area.
					add_square(1'b1, 1);
					add_square(1'b1, 2);
				end
				1: begin
					write_tolerance('1);
					add_square(1'b0, 2);
					add_random_polygons(RANDOM_BUDGET);
				end
				2: begin
					write_tolerance(TOL_W'(6000));
					// Doubled area exactly at the tolerance, one above it, and clockwise at it.
					add_vertex(0, 0, 1'b0);
					add_vertex(100, 0, 1'b0);
					add_vertex(0, 60, 1'b1);
					add_vertex(0, 0, 1'b0);
					add_vertex(17, 0, 1'b0);
					add_vertex(0, 353, 1'b1);
					add_vertex(0, 0, 1'b0);
					add_vertex(0, 60, 1'b0);
					add_vertex(100, 0, 1'b1);
					add_random_polygons(RANDOM_BUDGET);
				end
				3: begin
					write_tolerance(TOL_W'($urandom_range(1 << 26)));
					add_random_polygons(RANDOM_BUDGET);
				end
				4: begin
					write_tolerance(TOL_W'($urandom));
					add_random_polygons(RANDOM_BUDGET);
				end
				default: begin
					write_tolerance('0);
					add_random_polygons(RANDOM_BUDGET);
				end
			endcase

			// Let the block drain before the next register write.
			while (pending_vertices.size() != 0 || in_valid || expected_polygons.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end

		$display("Covered %0d vertex beats: %0d ok, %0d bad vertex count, %0d degenerate polygons.",
			vertex_beats, n_ok, n_count, n_degen);
		$display("%0d results saturated, %0d tolerance writes, %0d mismatches.",
			n_sat, tol_writes, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pca_pkg.sv
hdl/pca_div.sv
hdl/pca_front.sv
hdl/pca_queue.sv
hdl/pca_back.sv
hdl/polygon_centroid_area.sv
hdl/pca_checker.sv
tb/tb.sv
